>>> rtl/lasr_pkg.sv
`timescale 1ns / 1ps
package lasr_pkg;
	localparam int MaxShards = 16;
	localparam int LoadBits  = 32;
	localparam int IdxW      = $clog2(MaxShards);
	localparam int CntW      = $clog2(MaxShards + 1);
	// total of all counters plus headroom for the 3x and 2n scaling
	localparam int SumW      = LoadBits + CntW + 2;

	localparam logic [63:0] Mix1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] Mix2 = 64'hc4ceb9fe1a85ec53;

	localparam logic [1:0] RegHash  = 2'd0;
	localparam logic [1:0] RegRoute = 2'd1;
	localparam logic [1:0] RegCount = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MIX1, ST_MUL1, ST_MIX2, ST_MUL2, ST_MIX3,
		ST_MOD, ST_SUM, ST_CMP, ST_MIN, ST_OUT
	} state_t;

	// multiplier step: 64 x 64 low half, one 32x32 partial product a cycle
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;
endpackage

>>> rtl/lasr_mul.sv
`timescale 1ns / 1ps
// shared 64-bit multiplier: low 64 bits of a*b from three 32x32 products
module lasr_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  lasr_pkg::mul_req_t req,
	output lasr_pkg::mul_rsp_t rsp
);
	import lasr_pkg::*;

	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] op_a, op_b;
	logic [63:0] prod_s1;
	logic [63:0] term;

	// operand pick per step: lo*lo, lo*hi, hi*lo
	always_comb begin
		unique case (step_q)
			2'd0:    begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
			2'd1:    begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
			default: begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
		endcase
	end

	assign term = (step_q == 2'd1) ? prod_s1 : {prod_s1[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product register, then accumulate one step behind
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_s1 <= 64'(op_a * op_b);
		if (busy_q) begin
			unique case (step_q)
				2'd1:    acc_q <= prod_s1;
				2'd2:    acc_q <= acc_q + {prod_s1[31:0], 32'd0};
				2'd3:    acc_q <= acc_q + term;
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp = {done_q, acc_q};
endmodule

>>> rtl/lasr_load.sv
`timescale 1ns / 1ps
// load counter bank: saturating commits, one read port for the sequencer
module lasr_load (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           inc,
	input  logic [lasr_pkg::IdxW-1:0]      inc_idx,
	input  logic [lasr_pkg::IdxW-1:0]      rd_idx,
	output logic [lasr_pkg::LoadBits-1:0]  rd_data
);
	import lasr_pkg::*;

	logic [LoadBits-1:0] load_q [MaxShards];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxShards; i++) load_q[i] <= '0;
		end else if (inc && load_q[inc_idx] != '1) begin
			load_q[inc_idx] <= load_q[inc_idx] + 1'b1;
		end
	end

	assign rd_data = load_q[rd_idx];
endmodule

>>> rtl/lasr_seq.sv
`timescale 1ns / 1ps
// sequencer: hash, restoring modulo, counter scans
module lasr_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hash_mode,
	input  logic                           routing_mode,
	input  logic [lasr_pkg::CntW-1:0]      n_use,
	input  logic                           go,
	input  logic [31:0]                    key_in,
	input  logic                           out_free,
	output logic                           busy,
	output logic                           res_valid,
	output logic [lasr_pkg::IdxW-1:0]      res_chosen,
	output logic [lasr_pkg::IdxW-1:0]      res_natural,
	output logic                           res_redir,
	output logic [lasr_pkg::IdxW-1:0]      rd_idx,
	input  logic [lasr_pkg::LoadBits-1:0]  rd_data
);
	import lasr_pkg::*;

	state_t state_q, state_d;
	logic [63:0] h_q;
	logic [CntW-1:0] rem_q;
	logic [6:0] bit_q;
	logic [CntW-1:0] idx_q;
	logic [SumW-1:0] total_q;
	logic [LoadBits-1:0] best_load_q;
	logic [IdxW-1:0] best_q;
	logic [IdxW-1:0] nat_q;
	logic mul_issued_q;
	logic mul_start;
	logic [63:0] mul_b;
	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic [CntW:0] rem_sh;
	logic [SumW-1:0] lhs, rhs;

	lasr_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// one bit of h per cycle into the remainder
	assign rem_sh = {rem_q, h_q[63]};
	assign lhs = SumW'(rd_data) * SumW'({n_use, 1'b0});
	assign rhs = SumW'(total_q) * SumW'(3);
	assign rd_idx = (state_q == ST_CMP) ? nat_q : idx_q[IdxW-1:0];
	assign busy = (state_q != ST_IDLE);
	assign mul_b = (state_q == ST_MUL1) ? Mix1 : Mix2;
	assign mul_start = (state_q == ST_MUL1 || state_q == ST_MUL2) && !mul_issued_q;
	assign mreq = {mul_start, h_q, mul_b};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (go) state_d = hash_mode ? ST_MIX1 : ST_MOD;
			ST_MIX1: state_d = ST_MUL1;
			ST_MUL1: if (mrsp.done) state_d = ST_MIX2;
			ST_MIX2: state_d = ST_MUL2;
			ST_MUL2: if (mrsp.done) state_d = ST_MIX3;
			ST_MIX3: state_d = ST_MOD;
			ST_MOD:  if (bit_q == 7'd63) state_d = routing_mode ? ST_SUM : ST_OUT;
			ST_SUM:  if (idx_q == n_use - 1'b1) state_d = ST_CMP;
			ST_CMP:  state_d = (total_q != '0 && lhs > rhs) ? ST_MIN : ST_OUT;
			ST_MIN:  if (idx_q == n_use - 1'b1) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mul_issued_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			mul_issued_q <= mul_start ? 1'b1 : (mrsp.done ? 1'b0 : mul_issued_q);
			res_valid <= (state_q == ST_OUT) && out_free;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				h_q <= {{32{key_in[31]}}, key_in};
				rem_q <= '0;
				bit_q <= '0;
			end
			ST_MIX1, ST_MIX2, ST_MIX3: h_q <= h_q ^ {33'd0, h_q[63:33]};
			ST_MUL1, ST_MUL2: if (mrsp.done) h_q <= mrsp.p;
			ST_MOD: begin
				rem_q <= (rem_sh >= {1'b0, n_use}) ? CntW'(rem_sh - {1'b0, n_use})
					: rem_sh[CntW-1:0];
				h_q <= {h_q[62:0], 1'b0};
				bit_q <= bit_q + 7'd1;
				idx_q <= '0;
				total_q <= '0;
				if (bit_q == 7'd63) begin
					nat_q <= (rem_sh >= {1'b0, n_use}) ? IdxW'(rem_sh - {1'b0, n_use})
						: IdxW'(rem_sh);
					res_redir <= 1'b0;
				end
			end
			ST_SUM: begin
				total_q <= total_q + SumW'(rd_data);
				idx_q <= idx_q + 1'b1;
			end
			ST_CMP: begin
				idx_q <= '0;
				best_q <= '0;
				best_load_q <= '1;
			end
			ST_MIN: begin
				if (idx_q == '0 || rd_data < best_load_q) begin
					best_q <= idx_q[IdxW-1:0];
					best_load_q <= rd_data;
				end
				idx_q <= idx_q + 1'b1;
				res_redir <= 1'b1;
			end
			default: ;
		endcase
	end

	assign res_natural = nat_q;
	assign res_chosen = res_redir ? best_q : nat_q;
endmodule

>>> rtl/load_aware_shard_router_top.sv
`timescale 1ns / 1ps
// Key-to-shard router with load-aware hotspot redirection.
// Input channel (in_valid/in_stall): kind, key, commit_shard. A commit word
// bumps the chosen shard's saturating load counter, if below n, and gives no
// result. A route word hashes the sign-extended key (identity or the 64-bit
// finaliser), reduces it modulo the shard count and, in load-aware mode,
// redirects to the least-loaded shard when 2*n*load > 3*total.
// Output channel (out_valid/out_stall): chosen_shard, natural_shard, redirected.
// Per route: the identity hash or the finaliser (two multiplies on the shared
// 32x32 unit and three mix steps), then the 64-step bit-serial modulo, plus
// the counter scans in load-aware mode; the modulo dominates. One word is in
// flight; in_stall is high meanwhile and while a result waits in the output
// register.
// The result sits in a register; a stall on the output holds it and the block
// waits. Reset clears all load counters and sets hash 0, routing 0, 8 shards.
// Configuration: cfg_we, cfg_index, cfg_wdata, while idle.
module load_aware_shard_router_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic signed [31:0] key,
	input  logic [3:0]  commit_shard,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  chosen_shard,
	output logic [3:0]  natural_shard,
	output logic        redirected
);
	import lasr_pkg::*;

	logic hash_q, route_q;
	logic [4:0] count_q;
	logic [CntW-1:0] n_use;
	logic busy, res_valid, res_redir, acc, out_free;
	logic [IdxW-1:0] res_chosen, res_natural, rd_idx;
	logic [LoadBits-1:0] rd_data;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 1'b0;
			route_q <= 1'b0;
			count_q <= 5'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegHash:  hash_q <= cfg_wdata[0];
				RegRoute: route_q <= cfg_wdata[0];
				RegCount: count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign n_use = (count_q == 5'd0) ? CntW'(1)
		: (count_q > 5'(MaxShards)) ? CntW'(MaxShards) : CntW'(count_q);

	assign in_stall = busy || out_valid;
	assign acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	lasr_load u_load (
		.clk(clk), .arst_n(arst_n),
		.inc(acc && kind && {1'b0, commit_shard} < n_use),
		.inc_idx(commit_shard), .rd_idx(rd_idx), .rd_data(rd_data)
	);

	lasr_seq u_seq (
		.clk(clk), .arst_n(arst_n), .hash_mode(hash_q), .routing_mode(route_q),
		.n_use(n_use), .go(acc && !kind), .key_in(key), .out_free(out_free),
		.busy(busy), .res_valid(res_valid), .res_chosen(res_chosen),
		.res_natural(res_natural), .res_redir(res_redir),
		.rd_idx(rd_idx), .rd_data(rd_data)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_valid) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			chosen_shard <= res_chosen;
			natural_shard <= res_natural;
			redirected <= res_redir;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("word accepted while busy");
	a_nat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, natural_shard} < n_use) else $error("natural out of range");
	a_static: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !redirected) |-> chosen_shard == natural_shard)
		else $error("unredirected word changed shard");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import lasr_pkg::*;

	localparam int WatchLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = RegHash;
	logic [4:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic signed [31:0] key = '0;
	logic [3:0]  commit_shard = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  chosen_shard;
	logic [3:0]  natural_shard;
	logic        redirected;

	load_aware_shard_router_top dut (.*);

	always #4 clk = ~clk;

	typedef struct {
		logic [3:0] chosen;
		logic [3:0] natural_s;
		logic       redir;
	} route_t;

	// routing predictor and the queue of routes still owed by the block
	class route_board;
		logic [31:0] load [MaxShards];
		logic        hmode, rmode;
		logic [4:0]  count;
		route_t      pending [$];
		int          errors;

		function void clear();
			foreach (load[i]) load[i] = '0;
			hmode = 1'b0; rmode = 1'b0; count = 5'd8;
			pending.delete(); errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [4:0] v);
			if (idx == RegHash) hmode = v[0];
			else if (idx == RegRoute) rmode = v[0];
			else if (idx == RegCount) count = v;
		endfunction

		function logic [63:0] fmix(logic [63:0] h);
			h ^= h >> 33; h *= Mix1;
			h ^= h >> 33; h *= Mix2;
			h ^= h >> 33;
			return h;
		endfunction

		// note an accepted word
		function void note_word(logic k, logic [31:0] ky, logic [3:0] cs);
			int unsigned n;
			logic [63:0] h, nat;
			logic [95:0] total, lhs, rhs;
			int unsigned best;
			route_t r;
			n = (count == 0) ? 1 : (count > MaxShards ? MaxShards : count);
			if (k) begin
				if (cs < n && load[cs] != 32'hffffffff) load[cs] += 1;
				return;
			end
			h = {{32{ky[31]}}, ky};
			if (hmode) h = fmix(h);
			nat = h % n;
			r.natural_s = nat[3:0]; r.chosen = nat[3:0]; r.redir = 1'b0;
			if (rmode) begin
				total = '0;
				for (int i = 0; i < n; i++) total += load[i];
				lhs = 96'(load[nat]) * (2 * n);
				rhs = total * 3;
				if (total != 0 && lhs > rhs) begin
					best = 0;
					for (int i = 1; i < n; i++) if (load[i] < load[best]) best = i;
					r.chosen = best[3:0]; r.redir = 1'b1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_word(logic [3:0] c, logic [3:0] ns, logic rd);
			route_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: %0d %0d %0d", c, ns, rd);
				return;
			end
			e = pending.pop_front();
			if (e.chosen !== c || e.natural_s !== ns || e.redir !== rd) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
						e.chosen, e.natural_s, e.redir, c, ns, rd);
			end
		endfunction
	endclass

	route_board board = new();
	bit quiet_rx = 1'b0;
	bit quiet_tx = 1'b0;
	bit hold_rx = 1'b0;
	int idle_cycles = 0;

	// monitor: both channels sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_word(kind, key, commit_shard);
			if (out_valid && !out_stall)
				board.check_word(chosen_shard, natural_shard, redirected);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver stall
	always @(posedge clk)
		out_stall <= hold_rx || (!quiet_rx && $urandom_range(99) < 6);

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WatchLimit) begin
			$display("FAIL load_aware_shard_router_top");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [4:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
		board.set_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one word and hold it until taken
	task automatic send_word(logic k, logic [31:0] ky, logic [3:0] cs);
		while (!quiet_tx && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1; kind <= k; key <= ky; commit_shard <= cs;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_words(int num, int hot);
		logic [31:0] ky;
		for (int i = 0; i < num; i++) begin
			ky = $urandom;
			case ($urandom_range(3))
				0: ky = $urandom_range(40);
				1: ky = -$urandom_range(40);
				default: ;
			endcase
			if ($urandom_range(99) < 45)
				send_word(1'b1, $urandom,
					($urandom_range(99) < hot) ? 4'd0 : 4'($urandom));
			else
				send_word(1'b0, ky, 4'($urandom));
		end
	endtask

	initial begin
		board.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes under reset settings and both hashes
		send_word(1'b0, 32'h7fffffff, 4'd0);
		send_word(1'b0, 32'h80000000, 4'd15);
		send_word(1'b0, 32'hffffffff, 4'd0);
		send_word(1'b0, 32'h0, 4'd0);
		send_word(1'b1, 32'h0, 4'd15);
		send_word(1'b1, 32'hffffffff, 4'd3);
		send_word(1'b1, 32'h0, 4'd3);
		drain();
		write_reg(RegHash, 5'd1);
		write_reg(RegRoute, 5'd1);
		write_reg(RegCount, 5'd0);
		send_word(1'b0, 32'h12345678, 4'd0);
		send_word(1'b1, 32'h0, 4'd1);
		drain();
		write_reg(RegCount, 5'd31);
		send_word(1'b1, 32'h0, 4'd15);
		send_word(1'b1, 32'h0, 4'd15);
		send_word(1'b0, 32'h80000000, 4'd0);
		send_word(1'b0, 32'h7fffffff, 4'd0);
		drain();
		write_reg(RegCount, 5'd16);
		write_reg(RegHash, 5'd0);
		send_word(1'b0, 32'd15, 4'd0);
		send_word(1'b0, 32'd3, 4'd0);
		send_word(1'b0, 32'hfffffff1, 4'd0);
		drain();

		// random phases across settings
		for (int p = 0; p < 8; p++) begin
			write_reg(RegHash, 5'($urandom));
			write_reg(RegRoute, (p % 4 == 3) ? 5'd0 : 5'd1);
			case (p)
				0: write_reg(RegCount, 5'd1);
				1: write_reg(RegCount, 5'd16);
				2: write_reg(RegCount, 5'd0);
				3: write_reg(RegCount, 5'd31);
				default: write_reg(RegCount, 5'($urandom_range(2, 16)));
			endcase
			quiet_tx = (p == 5); quiet_rx = (p == 5);
			if (p == 2) fork
				begin
					hold_rx = 1'b1;
					repeat (600) @(posedge clk);
					hold_rx = 1'b0;
				end
			join_none
			random_words(85, (p % 2) ? 60 : 10);
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS load_aware_shard_router_top");
		else
			$display("FAIL load_aware_shard_router_top");
		$finish;
	end
endmodule
